// ===== rtl/core/nearest_seed_label_map_core_defines.svh =====
// Assertion macros shared by the nearest-seed label map RTL.
// No dependencies; expects i_clk and i_rst_n in the including scope.
`ifndef NEAREST_SEED_LABEL_MAP_CORE_DEFINES_SVH
`define NEAREST_SEED_LABEL_MAP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define NSLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nslm_pkg.sv =====
// Package for the nearest-seed label map: payload structs, codes and
// controller/datapath handshake structs. No dependencies.
package nslm_pkg;

    localparam int DIST_BITS      = 32;
    localparam int DIM_BITS       = 11;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_BITS   = 2;
    localparam int OUT_LABEL_BITS = 16;

    localparam logic [DIST_BITS-1:0] STEP_STRAIGHT   = 32'd8;
    localparam logic [DIST_BITS-1:0] STEP_DIAG_EXTRA = 32'd3;
    localparam logic [DIST_BITS-1:0] JUMP_PENALTY    = 32'd100000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PENALTY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_SEED = 2'd1,
        CMD_RUN  = 2'd2,
        CMD_READ = 2'd3
    } t_command;

    typedef enum logic {
        KIND_RUN  = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef struct packed {
        t_command    command;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic        walkable_in;
        logic [15:0] seed_label;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] label_out;
        logic [31:0] distance_out;
        logic        reached;
        logic        overflow;
    } t_result;

    typedef struct packed {
        logic clr_all;
        logic clr_reached;
        logic do_load;
        logic do_seed;
        logic do_read;
        logic pop;
        logic chk;
        logic cmp;
        logic nb_rd;
        logic push;
        logic k_adv;
        logic fin;
    } t_ctl_cmd;

    typedef struct packed {
        logic q_empty;
        logic sweep_last;
        logic in_grid;
        logic keep;
        logic nb_valid;
        logic k_last;
    } t_dp_stat;

    function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
                                                     input logic [DIST_BITS-1:0] b);
        logic [DIST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_BITS] ? {DIST_BITS{1'b1}} : s[DIST_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/nslm_controller.sv =====
// Sequencer for the nearest-seed label map: clearing sweeps and queue walk.
// Depends on nslm_pkg and nearest_seed_label_map_core_defines.svh.
`include "nearest_seed_label_map_core_defines.svh"

module nslm_controller
    import nslm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_command i_command,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd,
    output logic     o_busy
);

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_RUN_CLR,
        S_POP,
        S_CHK,
        S_CMP,
        S_NB,
        S_PUSH,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_INIT_CLR: o_cmd.clr_all = 1'b1;
            S_IDLE: begin
                o_cmd.do_load = accept && (i_command == CMD_LOAD);
                o_cmd.do_seed = accept && (i_command == CMD_SEED);
                o_cmd.do_read = accept && (i_command == CMD_READ);
            end
            S_RUN_CLR: o_cmd.clr_reached = 1'b1;
            S_POP:     o_cmd.pop = !i_stat.q_empty;
            S_CHK:     o_cmd.chk = 1'b1;
            S_CMP:     o_cmd.cmp = 1'b1;
            S_NB: begin
                o_cmd.nb_rd = i_stat.nb_valid;
                o_cmd.k_adv = !i_stat.nb_valid;
            end
            S_PUSH: begin
                o_cmd.push  = 1'b1;
                o_cmd.k_adv = 1'b1;
            end
            S_FIN:     o_cmd.fin = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_CLR;
            r_busy  <= 1'b1;
        end else begin
            unique case (r_state)
                S_INIT_CLR: begin
                    if (i_stat.sweep_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (accept && (i_command == CMD_RUN)) begin
                        r_state <= S_RUN_CLR;
                        r_busy  <= 1'b1;
                    end
                end
                S_RUN_CLR: if (i_stat.sweep_last) r_state <= S_POP;
                S_POP:     r_state <= i_stat.q_empty ? S_FIN : S_CHK;
                S_CHK:     r_state <= i_stat.in_grid ? S_CMP : S_POP;
                S_CMP:     r_state <= i_stat.keep ? S_NB : S_POP;
                S_NB: begin
                    if (i_stat.nb_valid) begin
                        r_state <= S_PUSH;
                    end else if (i_stat.k_last) begin
                        r_state <= S_POP;
                    end
                end
                S_PUSH:    r_state <= i_stat.k_last ? S_POP : S_NB;
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    `NSLM_ASSERT_NOW(a_pop_not_empty, o_cmd.pop, !i_stat.q_empty, "pop from empty queue")
    `NSLM_ASSERT_NOW(a_push_after_read, o_cmd.push, $past(o_cmd.nb_rd), "push without walk read")
    `NSLM_ASSERT_NEXT(a_run_goes_busy, accept && (i_command == CMD_RUN), r_busy, "run not busy")
    `NSLM_ASSERT_NOW(a_ready_only_idle, !r_busy, r_state == S_IDLE, "ready outside idle")

endmodule

// ===== rtl/core/nslm_datapath.sv =====
// Datapath for the nearest-seed label map: cell memories, work queue,
// distance arithmetic and result register. Depends on nslm_pkg.
module nslm_datapath
    import nslm_pkg::*;
#(
    parameter int GRID_W      = 256,
    parameter int GRID_H      = 256,
    parameter int LABEL_BITS  = 16,
    parameter int QUEUE_DEPTH = 65536
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  t_item                   i_item,
    input  t_ctl_cmd                i_cmd,
    output t_dp_stat                o_stat,
    output logic                    o_done,
    output t_result                 o_result
);

    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);
    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW    = $clog2(CELLS);
    localparam int QAW   = $clog2(QUEUE_DEPTH);
    localparam int QEW   = XW + YW + LABEL_BITS + DIST_BITS;

    localparam logic [DIM_BITS-1:0] GRID_W_D = DIM_BITS'(GRID_W);
    localparam logic [DIM_BITS-1:0] GRID_H_D = DIM_BITS'(GRID_H);
    localparam logic [DIM_BITS-1:0] DIM_ONE  = DIM_BITS'(1);

    // configuration
    logic             r_penalty;
    logic [CFG_W-1:0] r_grid_w;
    logic [CFG_W-1:0] r_grid_h;

    // memories
    logic                  m_walk    [CELLS];
    logic                  m_reached [CELLS];
    logic [LABEL_BITS-1:0] m_label   [CELLS];
    logic [DIST_BITS-1:0]  m_dist    [CELLS];
    logic [QEW-1:0]        m_queue   [QUEUE_DEPTH];

    logic                  r_walk_rd;
    logic                  r_reached_rd;
    logic [LABEL_BITS-1:0] r_label_rd;
    logic [DIST_BITS-1:0]  r_dist_rd;
    logic [QEW-1:0]        r_q_rd;

    logic [QAW-1:0]        r_q_head;
    logic [QAW-1:0]        r_q_tail;
    logic [QAW:0]          r_q_count;
    logic                  r_ovf;

    logic [AW-1:0]         r_sweep;
    logic [2:0]            r_k;
    logic [DIST_BITS-1:0]  r_ds;
    logic [DIST_BITS-1:0]  r_dd;
    logic                  r_walk_from;
    logic                  r_rd_pend;
    logic                  r_rd_in_store;
    logic                  r_done;
    t_result               r_out;

    logic [DIM_BITS-1:0]   w9, h9, eff_w, eff_h;
    logic                  item_in_store, item_in_use;
    logic [AW-1:0]         item_addr;
    logic [XW-1:0]         e_x;
    logic [YW-1:0]         e_y;
    logic [LABEL_BITS-1:0] e_label;
    logic [DIST_BITS-1:0]  e_dist;
    logic [AW-1:0]         e_cell;
    logic                  nl, nr, nu, nd;
    logic                  nb_valid, nb_diag;
    logic [XW-1:0]         nx;
    logic [YW-1:0]         ny;
    logic [AW-1:0]         nb_addr;
    logic                  keep;
    logic [DIST_BITS-1:0]  ds_new, dd_new, push_base, push_dist;
    logic                  q_full;
    logic                  push_req;
    logic [QEW-1:0]        push_data;
    logic [AW-1:0]         walk_ra, cell_ra, sweep_addr;

    // effective grid size: zero acts as one, clamp to storage
    assign w9    = DIM_BITS'(r_grid_w);
    assign h9    = DIM_BITS'(r_grid_h);
    assign eff_w = (w9 == '0) ? DIM_ONE : ((w9 > GRID_W_D) ? GRID_W_D : w9);
    assign eff_h = (h9 == '0) ? DIM_ONE : ((h9 > GRID_H_D) ? GRID_H_D : h9);

    assign item_in_store = (DIM_BITS'(i_item.cell_x) < GRID_W_D)
                        && (DIM_BITS'(i_item.cell_y) < GRID_H_D);
    assign item_in_use   = (DIM_BITS'(i_item.cell_x) < eff_w)
                        && (DIM_BITS'(i_item.cell_y) < eff_h);
    assign item_addr     = AW'(YW'(i_item.cell_y)) * AW'(GRID_W) + AW'(XW'(i_item.cell_x));

    assign {e_x, e_y, e_label, e_dist} = r_q_rd;
    assign e_cell = AW'(e_y) * AW'(GRID_W) + AW'(e_x);

    assign nl = (e_x != '0);
    assign nr = (DIM_BITS'(e_x) + DIM_ONE) < eff_w;
    assign nu = (e_y != '0);
    assign nd = (DIM_BITS'(e_y) + DIM_ONE) < eff_h;

    // neighbour order: left, right, up, down, then the four diagonals
    always_comb begin
        nx       = e_x;
        ny       = e_y;
        nb_valid = 1'b0;
        nb_diag  = r_k[2];
        unique case (r_k)
            3'd0: begin nb_valid = nl;      nx = e_x - 1'b1; end
            3'd1: begin nb_valid = nr;      nx = e_x + 1'b1; end
            3'd2: begin nb_valid = nu;      ny = e_y - 1'b1; end
            3'd3: begin nb_valid = nd;      ny = e_y + 1'b1; end
            3'd4: begin nb_valid = nl & nu; nx = e_x - 1'b1; ny = e_y - 1'b1; end
            3'd5: begin nb_valid = nl & nd; nx = e_x - 1'b1; ny = e_y + 1'b1; end
            3'd6: begin nb_valid = nr & nu; nx = e_x + 1'b1; ny = e_y - 1'b1; end
            3'd7: begin nb_valid = nr & nd; nx = e_x + 1'b1; ny = e_y + 1'b1; end
            default: nb_valid = 1'b0;
        endcase
    end
    assign nb_addr = AW'(ny) * AW'(GRID_W) + AW'(nx);

    assign keep   = !r_reached_rd || (r_dist_rd > e_dist);
    assign ds_new = sat_add(e_dist, STEP_STRAIGHT);
    assign dd_new = sat_add(ds_new, STEP_DIAG_EXTRA);

    assign push_base = nb_diag ? r_dd : r_ds;
    assign push_dist = (r_penalty && r_walk_from && !r_walk_rd)
                     ? sat_add(push_base, JUMP_PENALTY) : push_base;

    assign q_full   = (r_q_count == (QAW+1)'(QUEUE_DEPTH));
    assign push_req = (i_cmd.do_seed && item_in_use) || i_cmd.push;
    assign push_data = i_cmd.push
        ? {nx, ny, e_label, push_dist}
        : {XW'(i_item.cell_x), YW'(i_item.cell_y), LABEL_BITS'(i_item.seed_label),
           {DIST_BITS{1'b0}}};

    assign walk_ra    = i_cmd.chk ? e_cell : nb_addr;
    assign cell_ra    = i_cmd.do_read ? item_addr : e_cell;
    assign sweep_addr = r_sweep;

    // walkable map
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_all) begin
            m_walk[sweep_addr] <= 1'b0;
        end else if (i_cmd.do_load && item_in_store) begin
            m_walk[item_addr] <= i_item.walkable_in;
        end
        r_walk_rd <= m_walk[walk_ra];
    end

    // reached, label and distance maps
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_all || i_cmd.clr_reached) begin
            m_reached[sweep_addr] <= 1'b0;
        end else if (i_cmd.cmp && keep) begin
            m_reached[e_cell] <= 1'b1;
        end
        if (i_cmd.cmp && keep) begin
            m_label[e_cell] <= e_label;
            m_dist[e_cell]  <= e_dist;
        end
        r_reached_rd <= m_reached[cell_ra];
        r_label_rd   <= m_label[cell_ra];
        r_dist_rd    <= m_dist[cell_ra];
    end

    // work queue storage
    always_ff @(posedge i_clk) begin
        if (push_req && !q_full) begin
            m_queue[r_q_tail] <= push_data;
        end
        if (i_cmd.pop) begin
            r_q_rd <= m_queue[r_q_head];
        end
    end

    // per-entry working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_ds        <= ds_new;
            r_dd        <= dd_new;
            r_walk_from <= r_walk_rd;
        end
        if (i_cmd.do_read) begin
            r_rd_in_store <= item_in_store;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penalty <= 1'b0;
            r_grid_w  <= CFG_W'(256);
            r_grid_h  <= CFG_W'(256);
            r_q_head  <= '0;
            r_q_tail  <= '0;
            r_q_count <= '0;
            r_ovf     <= 1'b0;
            r_sweep   <= '0;
            r_k       <= '0;
            r_rd_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PENALTY: r_penalty <= i_cfg_data[0];
                    CFG_WIDTH:   r_grid_w  <= i_cfg_data;
                    CFG_HEIGHT:  r_grid_h  <= i_cfg_data;
                    default:     r_penalty <= r_penalty;
                endcase
            end

            if (i_cmd.clr_all || i_cmd.clr_reached) begin
                r_sweep <= (r_sweep == AW'(CELLS - 1)) ? '0 : r_sweep + 1'b1;
            end

            if (i_cmd.cmp) begin
                r_k <= '0;
            end else if (i_cmd.k_adv) begin
                r_k <= r_k + 1'b1;
            end

            // queue pointers: pushes and pops never share a cycle
            if (push_req) begin
                if (q_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_q_tail  <= (r_q_tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_q_tail + 1'b1;
                    r_q_count <= r_q_count + 1'b1;
                end
            end else if (i_cmd.pop) begin
                r_q_head  <= (r_q_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_q_head + 1'b1;
                r_q_count <= r_q_count - 1'b1;
            end else if (i_cmd.fin) begin
                r_q_head <= '0;
                r_q_tail <= '0;
                r_ovf    <= 1'b0;
            end

            r_rd_pend <= i_cmd.do_read;
            r_done    <= r_rd_pend || i_cmd.fin;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out.kind         <= KIND_RUN;
            r_out.label_out    <= '0;
            r_out.distance_out <= '0;
            r_out.reached      <= 1'b0;
            r_out.overflow     <= r_ovf;
        end else if (r_rd_pend) begin
            r_out.kind         <= KIND_READ;
            r_out.overflow     <= 1'b0;
            if (r_rd_in_store && r_reached_rd) begin
                r_out.label_out    <= OUT_LABEL_BITS'(r_label_rd);
                r_out.distance_out <= r_dist_rd;
                r_out.reached      <= 1'b1;
            end else begin
                r_out.label_out    <= '0;
                r_out.distance_out <= '0;
                r_out.reached      <= 1'b0;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    assign o_stat.q_empty    = (r_q_count == '0);
    assign o_stat.sweep_last = (r_sweep == AW'(CELLS - 1));
    assign o_stat.in_grid    = (DIM_BITS'(e_x) < eff_w) && (DIM_BITS'(e_y) < eff_h);
    assign o_stat.keep       = keep;
    assign o_stat.nb_valid   = nb_valid;
    assign o_stat.k_last     = (r_k == 3'd7);

endmodule

// ===== rtl/core/nearest_seed_label_map_core.sv =====
// Top level of the nearest-seed label map: controller plus datapath.
// Depends on nslm_pkg, nslm_controller and nslm_datapath.
//
// Loads, seed adds and cell reads are taken one per cycle while busy is
// low; a read's result passes a pending flag and the result register
// before it shows on o_result. A run holds busy high: first a clearing
// pass over every cell of the reached map, then the work queue is drained
// one entry at a time through the shared cell memories. A popped entry in
// the grid in use is compared with the stored distance; a kept one walks
// its eight neighbours and pushes each that lies in the grid. When a pop
// finds the queue empty, the finish state follows and the finish item is
// delivered on the cycle after. After reset the block is busy while the
// walkable and reached maps are cleared over every cell. Each result sits
// on o_result for exactly one cycle with o_done high; the receiver cannot
// stall it, so sample it on that cycle.
module nearest_seed_label_map_core
    import nslm_pkg::*;
#(
    parameter int GRID_W      = 256,
    parameter int GRID_H      = 256,
    parameter int LABEL_BITS  = 16,
    parameter int QUEUE_DEPTH = 65536
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  t_item                   i_item,
    output logic                    o_done,
    output t_result                 o_result
);

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    // sequence the commands and the propagation loop
    nslm_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_stat    (dp_stat),
        .o_cmd     (ctl_cmd),
        .o_busy    (busy)
    );

    // hold the maps, the queue and the result register
    nslm_datapath #(
        .GRID_W      (GRID_W),
        .GRID_H      (GRID_H),
        .LABEL_BITS  (LABEL_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (ctl_cmd),
        .o_stat     (dp_stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule
